// File: src/qme_pkg.sv
// Shared constants, codes and types of the queue machine executor.
`default_nettype none
package qme_pkg;

	// Word width of the queue, the registers and the arithmetic unit.
	localparam int DATA_W = 16;

	// Queue storage: depth, pointer width and fill count width.
	localparam int QUEUE_DEPTH = 1024;
	localparam int QA_W = $clog2(QUEUE_DEPTH);
	localparam int QC_W = QA_W + 1;

	// Program size, used to saturate jump targets.
	localparam int PROGRAM_LINES = 4096;
	localparam int TGT_W = 12;
	localparam logic [TGT_W-1:0] TGT_LAST = TGT_W'(PROGRAM_LINES - 1);

	// General registers a..z.
	localparam int NUM_REGS = 26;
	localparam int REG_W = 5;

	// Instruction codes.
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 5'd1;
	localparam logic [OP_W-1:0] OP_SUB      = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL      = 5'd3;
	localparam logic [OP_W-1:0] OP_DIV      = 5'd4;
	localparam logic [OP_W-1:0] OP_MOD      = 5'd5;
	localparam logic [OP_W-1:0] OP_STORE    = 5'd6;
	localparam logic [OP_W-1:0] OP_LOAD     = 5'd7;
	localparam logic [OP_W-1:0] OP_PRN_NQ   = 5'd8;
	localparam logic [OP_W-1:0] OP_PRN_NR   = 5'd9;
	localparam logic [OP_W-1:0] OP_PRN_CQ   = 5'd10;
	localparam logic [OP_W-1:0] OP_PRN_CR   = 5'd11;
	localparam logic [OP_W-1:0] OP_JMP      = 5'd12;
	localparam logic [OP_W-1:0] OP_JZ       = 5'd13;
	localparam logic [OP_W-1:0] OP_JEQ      = 5'd14;
	localparam logic [OP_W-1:0] OP_JGT      = 5'd15;
	localparam logic [OP_W-1:0] OP_QUIT     = 5'd16;
	localparam logic [OP_W-1:0] OP_PUSH     = 5'd17;

	// Result kinds.
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
	localparam logic [KIND_W-1:0] K_NUMBER = 3'd1;
	localparam logic [KIND_W-1:0] K_CHAR   = 3'd2;
	localparam logic [KIND_W-1:0] K_JUMP   = 3'd3;
	localparam logic [KIND_W-1:0] K_HALT   = 3'd4;
	localparam logic [KIND_W-1:0] K_UNDER  = 3'd5;
	localparam logic [KIND_W-1:0] K_OVER   = 3'd6;

	// Operations of the shared arithmetic unit.
	localparam int ALU_OP_W = 3;
	localparam logic [ALU_OP_W-1:0] ALU_ADD = 3'd0;
	localparam logic [ALU_OP_W-1:0] ALU_SUB = 3'd1;
	localparam logic [ALU_OP_W-1:0] ALU_MUL = 3'd2;
	localparam logic [ALU_OP_W-1:0] ALU_DIV = 3'd3;
	localparam logic [ALU_OP_W-1:0] ALU_MOD = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [REG_W-1:0]  reg_first;
		logic [REG_W-1:0]  reg_second;
		logic [DATA_W-1:0] immediate;
		logic [TGT_W-1:0]  target_line;
	} cmd_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [DATA_W-1:0] out_value;
		logic [TGT_W-1:0]  jump_target;
	} res_item_t;

	typedef struct packed {
		logic                start;
		logic [ALU_OP_W-1:0] op;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] res;
		logic              eq;
		logic              gt;
	} alu_rsp_t;

endpackage
`default_nettype wire

// File: src/qme_if.sv
// Valid/ready channel interfaces for instructions and results.
`default_nettype none
interface qme_cmd_if;
	logic               valid;
	logic               ready;
	qme_pkg::cmd_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface qme_res_if;
	logic               valid;
	logic               ready;
	qme_pkg::res_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/queue_machine_executor.sv
// Top level of the queue machine executor: sequencer, queue, registers and result register.
//
// The block executes one decoded queue machine instruction per beat on the
// cmd channel and returns exactly one beat on the res channel for each.
// Both channels are valid/ready: a beat moves on a rising edge of clk at
// which valid and ready are both high.
//
// cmd.ready is high only while the sequencer is idle. An accepted
// instruction is decoded and then, as it needs them, pops one queue word
// (POPX), pops a second (POPY) or starts a register compare (CMP), and waits
// on the shared unit, which produces one quotient bit per cycle for div and
// mod, before its result is loaded into the output register. The sequencer
// then returns to idle before it takes the next instruction.
//
// A stalled receiver holds the result in the output register while the next
// instruction is taken and executed; only that one then waits for it.
// Reset (arst_n low) empties the queue and the output register and clears
// all 26 registers. The queue memory is not cleared: only entries counted by
// the fill count are ever read.
`default_nettype none
module queue_machine_executor (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qme_cmd_if.sink    cmd,
	qme_res_if.source  res
);

	localparam int DW   = qme_pkg::DATA_W;
	localparam int QA_W = qme_pkg::QA_W;
	localparam int QC_W = qme_pkg::QC_W;

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_POPX   = 3'd2;
	localparam logic [2:0] S_POPY   = 3'd3;
	localparam logic [2:0] S_CMP    = 3'd4;
	localparam logic [2:0] S_WAIT   = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0]          state_q, state_d;
	qme_pkg::cmd_item_t  cur_q;
	logic [QA_W-1:0]     head_q, head_d;
	logic [QC_W-1:0]     count_q, count_d;
	logic [DW-1:0]       x_q, x_d;
	qme_pkg::res_item_t  pend_q, pend_d;
	logic                out_valid_q;
	qme_pkg::res_item_t  out_q;
	logic [DW-1:0]       rf_q [qme_pkg::NUM_REGS];

	// Queue memory port signals.
	logic                ram_we;
	logic [QA_W-1:0]     ram_waddr;
	logic [DW-1:0]       ram_wdata;
	logic [QA_W-1:0]     ram_raddr;
	logic [DW-1:0]       ram_rdata;

	// Register file port signals: one read address and one write per cycle.
	logic [qme_pkg::REG_W-1:0] rf_raddr;
	logic [DW-1:0]             rf_rdata;
	logic                      rf_we;

	qme_pkg::alu_req_t   alu_req;
	qme_pkg::alu_rsp_t   alu_rsp;

	logic [QA_W-1:0]     head_inc;
	logic [QC_W-1:0]     tail_sum;
	logic [QC_W-1:0]     tail;
	logic                q_full;
	logic                out_load;
	logic                take_jump;
	logic [qme_pkg::ALU_OP_W-1:0] arith_op;
	logic [qme_pkg::TGT_W-1:0]    tgt_sat;

	qme_ram #(
		.WIDTH (DW),
		.DEPTH (qme_pkg::QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	qme_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Queue pointer arithmetic. The depth need not be a power of two, so the
	// wrap is an explicit compare; head plus count stays below twice the depth.
	always_comb begin
		head_inc  = (head_q == QA_W'(qme_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_sum  = QC_W'(head_q) + count_q;
		tail      = (tail_sum >= QC_W'(qme_pkg::QUEUE_DEPTH)) ?
			tail_sum - QC_W'(qme_pkg::QUEUE_DEPTH) : tail_sum;
		ram_waddr = tail[QA_W-1:0];
		q_full    = (count_q == QC_W'(qme_pkg::QUEUE_DEPTH));
	end

	// Register read: an index beyond z reads as zero.
	assign rf_rdata = (rf_raddr < qme_pkg::REG_W'(qme_pkg::NUM_REGS)) ? rf_q[rf_raddr] : '0;

	// Jump targets beyond the program are clamped to its last line.
	assign tgt_sat = (cmd.data.target_line > qme_pkg::TGT_LAST) ?
		qme_pkg::TGT_LAST : cmd.data.target_line;

	always_comb begin
		unique case (cur_q.operation)
			qme_pkg::OP_SUB: arith_op = qme_pkg::ALU_SUB;
			qme_pkg::OP_MUL: arith_op = qme_pkg::ALU_MUL;
			qme_pkg::OP_DIV: arith_op = qme_pkg::ALU_DIV;
			qme_pkg::OP_MOD: arith_op = qme_pkg::ALU_MOD;
			default:         arith_op = qme_pkg::ALU_ADD;
		endcase
	end

	assign take_jump = (cur_q.operation == qme_pkg::OP_JGT) ? alu_rsp.gt : alu_rsp.eq;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || res.ready);
	assign cmd.ready = (state_q == S_IDLE);

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		x_d       = x_q;
		pend_d    = pend_q;
		ram_we    = 1'b0;
		ram_wdata = rf_rdata;
		ram_raddr = head_q;
		rf_raddr  = cur_q.reg_first;
		rf_we     = 1'b0;
		alu_req   = '{start: 1'b0, op: qme_pkg::ALU_ADD, a: x_q, b: '0};

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				pend_d  = '0;
				state_d = S_OUT;
				unique case (cur_q.operation) inside
					qme_pkg::OP_ADD, qme_pkg::OP_SUB, qme_pkg::OP_MUL,
					qme_pkg::OP_DIV, qme_pkg::OP_MOD: begin
						if (count_q < QC_W'(2)) begin
							pend_d.result_kind = qme_pkg::K_UNDER;
						end else begin
							state_d = S_POPX;
						end
					end
					qme_pkg::OP_STORE, qme_pkg::OP_PRN_NQ, qme_pkg::OP_PRN_CQ: begin
						if (count_q == '0) begin
							pend_d.result_kind = qme_pkg::K_UNDER;
						end else begin
							state_d = S_POPX;
						end
					end
					qme_pkg::OP_LOAD, qme_pkg::OP_PUSH: begin
						if (q_full) begin
							pend_d.result_kind = qme_pkg::K_OVER;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = (cur_q.operation == qme_pkg::OP_PUSH) ?
								cur_q.immediate : rf_rdata;
							count_d   = count_q + 1'b1;
						end
					end
					qme_pkg::OP_PRN_NR: begin
						pend_d.result_kind = qme_pkg::K_NUMBER;
						pend_d.out_value   = rf_rdata;
					end
					qme_pkg::OP_PRN_CR: begin
						pend_d.result_kind = qme_pkg::K_CHAR;
						pend_d.out_value   = {8'h00, rf_rdata[7:0]};
					end
					qme_pkg::OP_JMP: begin
						pend_d.result_kind = qme_pkg::K_JUMP;
						pend_d.jump_target = cur_q.target_line;
					end
					qme_pkg::OP_JZ, qme_pkg::OP_JEQ, qme_pkg::OP_JGT: begin
						x_d     = rf_rdata;
						state_d = S_CMP;
					end
					qme_pkg::OP_QUIT: begin
						pend_d.result_kind = qme_pkg::K_HALT;
					end
					default: begin
					end
				endcase
			end
			S_POPX: begin
				// Oldest word has arrived from the memory; ask for the next one.
				head_d    = head_inc;
				count_d   = count_q - 1'b1;
				x_d       = ram_rdata;
				ram_raddr = head_inc;
				state_d   = S_OUT;
				if (cur_q.operation == qme_pkg::OP_STORE) begin
					rf_we = 1'b1;
				end else if (cur_q.operation == qme_pkg::OP_PRN_NQ) begin
					pend_d.result_kind = qme_pkg::K_NUMBER;
					pend_d.out_value   = ram_rdata;
				end else if (cur_q.operation == qme_pkg::OP_PRN_CQ) begin
					pend_d.result_kind = qme_pkg::K_CHAR;
					pend_d.out_value   = {8'h00, ram_rdata[7:0]};
				end else begin
					state_d = S_POPY;
				end
			end
			S_POPY: begin
				head_d  = head_inc;
				count_d = count_q - 1'b1;
				alu_req = '{start: 1'b1, op: arith_op, a: x_q, b: ram_rdata};
				state_d = S_WAIT;
			end
			S_CMP: begin
				// Jump if zero compares against a constant zero.
				rf_raddr = cur_q.reg_second;
				alu_req  = '{start: 1'b1, op: qme_pkg::ALU_SUB, a: x_q,
					b: (cur_q.operation == qme_pkg::OP_JZ) ? '0 : rf_rdata};
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				if (alu_rsp.done) begin
					state_d = S_OUT;
					if (cur_q.operation < qme_pkg::OP_STORE) begin
						ram_we    = 1'b1;
						ram_wdata = alu_rsp.res;
						count_d   = count_q + 1'b1;
					end else if (take_jump) begin
						pend_d.result_kind = qme_pkg::K_JUMP;
						pend_d.jump_target = cur_q.target_line;
					end
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < qme_pkg::NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			// A store to an index beyond z pops the word and drops it.
			if (rf_we && (cur_q.reg_first < qme_pkg::REG_W'(qme_pkg::NUM_REGS))) begin
				rf_q[cur_q.reg_first] <= ram_rdata;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		x_q    <= x_d;
		pend_q <= pend_d;
		if (cmd.valid && cmd.ready) begin
			cur_q <= '{operation: cmd.data.operation, reg_first: cmd.data.reg_first,
				reg_second: cmd.data.reg_second, immediate: cmd.data.immediate,
				target_line: tgt_sat};
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule
`default_nettype wire

// File: src/qme_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module qme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/qme_alu.sv
// Shared arithmetic unit: registered add, subtract/compare and multiply,
// and a restoring divider that produces one quotient bit per cycle.
`default_nettype none
module qme_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qme_pkg::alu_req_t req,
	output qme_pkg::alu_rsp_t      rsp
);

	localparam int DW    = qme_pkg::DATA_W;
	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             mod_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dq_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    res_q;
	logic             eq_q;
	logic             gt_q;

	logic [DW:0]      diff;
	logic [2*DW-1:0]  prod;
	logic [DW:0]      rem_sh;
	logic             ge;
	logic [DW-1:0]    rem_nx;
	logic [DW-1:0]    dq_nx;

	always_comb begin
		diff   = {1'b0, req.a} - {1'b0, req.b};
		prod   = req.a * req.b;
		// One restoring step: shift in the next dividend bit, subtract if it fits.
		rem_sh = {rem_q, dq_q[DW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
		dq_nx  = {dq_q[DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				cnt_q <= '0;
				if (req.op == qme_pkg::ALU_DIV || req.op == qme_pkg::ALU_MOD) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_nx;
			dq_q  <= dq_nx;
			if (cnt_q == CNT_W'(DW - 1)) begin
				// A zero divisor gives zero for both quotient and remainder.
				res_q <= (den_q == '0) ? '0 : (mod_q ? rem_nx : dq_nx);
			end
		end else if (req.start) begin
			eq_q <= (diff[DW-1:0] == '0);
			gt_q <= !diff[DW] && (diff[DW-1:0] != '0);
			unique case (req.op) inside
				qme_pkg::ALU_ADD: res_q <= DW'(req.a + req.b);
				qme_pkg::ALU_SUB: res_q <= diff[DW-1:0];
				qme_pkg::ALU_MUL: res_q <= prod[DW-1:0];
				qme_pkg::ALU_DIV, qme_pkg::ALU_MOD: begin
					rem_q <= '0;
					dq_q  <= req.a;
					den_q <= req.b;
					mod_q <= (req.op == qme_pkg::ALU_MOD);
				end
				default: res_q <= '0;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
	assign rsp.eq   = eq_q;
	assign rsp.gt   = gt_q;

endmodule
`default_nettype wire

// File: src/qme_checker.sv
// Port-level checks on the queue machine executor and their binding to the top level.
`default_nettype none
module qme_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_ready,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire qme_pkg::res_item_t res_data
);

	// A result waiting for the receiver stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// The block works on one instruction at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("instruction accepted while the previous one is executing");

	// The jump target is only reported for a taken jump.
	a_target_only_on_jump: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.result_kind != qme_pkg::K_JUMP) |-> res_data.jump_target == '0)
		else $error("jump target set on a result that is no jump");

	// Only number results carry a high byte; every other kind, a character too, has it zero.
	a_value_only_on_print: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.result_kind != qme_pkg::K_NUMBER) |-> res_data.out_value[15:8] == '0)
		else $error("value high byte set on a result that is no number");

endmodule

bind queue_machine_executor qme_checker u_qme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire

// File: tb/queue_machine_executor_tb.sv
// Self-checking testbench for the queue machine executor, with its own instruction predictor.
`timescale 1ns / 1ps
module queue_machine_executor_tb;
	import qme_pkg::*;

	// Size of the random part and of its closing stretch that runs without idling.
	localparam int RANDOM_ITEMS = 890;
	localparam int QUIET_TAIL = 300;
	// Length of the long receiver hold-off, in cycles.
	localparam int LONG_HOLD = 300;
	// First unused operation code; highest codes of the 5-bit operation and register fields.
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_PUSH + 1'b1;
	localparam logic [OP_W-1:0] OP_LAST_CODE = {OP_W{1'b1}};
	localparam logic [REG_W-1:0] REG_LAST_INDEX = {REG_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;

	qme_cmd_if cmd_ch ();
	qme_res_if res_ch ();

	queue_machine_executor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// 2 ns clock period.
	always #1 clk = ~clk;

	// Shadow copy of the machine state: the word queue and registers a..z.
	logic [DATA_W-1:0] shadow_queue[$];
	logic [DATA_W-1:0] shadow_regs[NUM_REGS];

	// Results predicted for accepted instructions, oldest first.
	res_item_t predicted_results[$];

	// Run bookkeeping.
	bit idling_on;
	int hold_request;
	int sent_items;
	int results_seen;
	int failures;
	int peak_level;
	int kind_count[8];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Register read; indexes beyond z read as zero.
	function automatic logic [DATA_W-1:0] reg_value(logic [REG_W-1:0] idx);
		return (idx < NUM_REGS) ? shadow_regs[idx] : '0;
	endfunction

	// Executes one instruction on the shadow state and returns the result beat
	// that the block ought to send for it.
	function automatic res_item_t execute_instr(cmd_item_t c);
		res_item_t r;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] w;
		logic [TGT_W-1:0] tgt;
		logic taken;
		r = '0;
		taken = 1'b0;
		w = '0;
		tgt = c.target_line;
		// Targets beyond the program are clamped to its last line.
		if (int'(tgt) >= PROGRAM_LINES)
			tgt = TGT_LAST;
		case (c.operation)
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
			if (shadow_queue.size() < 2) begin
				r.result_kind = K_UNDER;
			end else begin
				x = shadow_queue.pop_front();
				y = shadow_queue.pop_front();
				case (c.operation)
				OP_ADD: w = x + y;
				OP_SUB: w = x - y;
				OP_MUL: w = x * y;
				// Division and remainder by zero both give zero.
				OP_DIV: w = (y != 0) ? x / y : '0;
				default: w = (y != 0) ? x % y : '0;
				endcase
				shadow_queue = {shadow_queue, w};
			end
		end
		OP_STORE: begin
			if (shadow_queue.size() < 1) begin
				r.result_kind = K_UNDER;
			end else begin
				// A store beyond z still pops; the word is simply lost.
				w = shadow_queue.pop_front();
				if (c.reg_first < NUM_REGS)
					shadow_regs[c.reg_first] = w;
			end
		end
		OP_LOAD, OP_PUSH: begin
			if (shadow_queue.size() >= QUEUE_DEPTH) begin
				r.result_kind = K_OVER;
			end else begin
				w = (c.operation == OP_LOAD) ? reg_value(c.reg_first) : c.immediate;
				shadow_queue = {shadow_queue, w};
			end
		end
		OP_PRN_NQ, OP_PRN_CQ: begin
			if (shadow_queue.size() < 1) begin
				r.result_kind = K_UNDER;
			end else begin
				r.out_value = shadow_queue.pop_front();
				r.result_kind = (c.operation == OP_PRN_NQ) ? K_NUMBER : K_CHAR;
			end
		end
		OP_PRN_NR, OP_PRN_CR: begin
			r.out_value = reg_value(c.reg_first);
			r.result_kind = (c.operation == OP_PRN_NR) ? K_NUMBER : K_CHAR;
		end
		OP_JMP: taken = 1'b1;
		OP_JZ: taken = (reg_value(c.reg_first) == '0);
		OP_JEQ: taken = (reg_value(c.reg_first) == reg_value(c.reg_second));
		OP_JGT: taken = (reg_value(c.reg_first) > reg_value(c.reg_second));
		OP_QUIT: r.result_kind = K_HALT;
		// Nop and the unused codes leave everything alone.
		default: ;
		endcase
		// Characters carry only the low byte.
		if (r.result_kind == K_CHAR)
			r.out_value[DATA_W-1:8] = '0;
		if (taken) begin
			r.result_kind = K_JUMP;
			r.jump_target = tgt;
		end
		if (shadow_queue.size() > peak_level)
			peak_level = shadow_queue.size();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Instruction building
	// ------------------------------------------------------------------

	function automatic cmd_item_t instr(logic [OP_W-1:0] op, logic [REG_W-1:0] ra,
		logic [REG_W-1:0] rb, logic [DATA_W-1:0] imm, logic [TGT_W-1:0] tgt);
		cmd_item_t c;
		c.operation = op;
		c.reg_first = ra;
		c.reg_second = rb;
		c.immediate = imm;
		c.target_line = tgt;
		return c;
	endfunction

	// Random register index; now and then one beyond z.
	function automatic logic [REG_W-1:0] random_reg();
		if ($urandom_range(0, 9) == 0)
			return REG_W'($urandom_range(NUM_REGS, REG_LAST_INDEX));
		return REG_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	// Random word, leaning towards zero, small values and all ones so that
	// the compare jumps and division by zero come up often.
	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1, 2: return DATA_W'($urandom_range(1, 3));
		3: return {DATA_W{1'b1}};
		default: return DATA_W'($urandom);
		endcase
	endfunction

	// A random instruction whose mix depends on how full the queue is, so
	// the queue hovers at a modest level, runs dry now and then, and most
	// pops find data to work on.
	function automatic cmd_item_t random_instr(int level);
		cmd_item_t c;
		int push_weight;
		int pick;
		c = instr(OP_NOP, random_reg(), random_reg(), random_word(), TGT_W'($urandom));
		if ($urandom_range(0, 3) == 0)
			c.reg_second = c.reg_first;
		push_weight = (level < 6) ? 50 : (level > 30) ? 15 : 32;
		if ($urandom_range(0, 99) < push_weight) begin
			c.operation = ($urandom_range(0, 2) == 0) ? OP_LOAD : OP_PUSH;
			return c;
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// Division and remainder are slow, so each is picked less often than the rest.
			case ($urandom_range(0, 8))
			0, 1: c.operation = OP_ADD;
			2, 3: c.operation = OP_SUB;
			4, 5: c.operation = OP_MUL;
			6: c.operation = OP_DIV;
			7: c.operation = OP_MOD;
			default: c.operation = OP_ADD;
			endcase
		end else if (pick < 45) begin
			c.operation = OP_STORE;
		end else if (pick < 62) begin
			case ($urandom_range(0, 3))
			0: c.operation = OP_PRN_NQ;
			1: c.operation = OP_PRN_NR;
			2: c.operation = OP_PRN_CQ;
			default: c.operation = OP_PRN_CR;
			endcase
		end else if (pick < 88) begin
			case ($urandom_range(0, 3))
			0: c.operation = OP_JMP;
			1: c.operation = OP_JZ;
			2: c.operation = OP_JEQ;
			default: c.operation = OP_JGT;
			endcase
		end else if (pick < 92) begin
			c.operation = OP_QUIT;
		end else if (pick < 96) begin
			c.operation = OP_NOP;
		end else begin
			c.operation = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Instruction channel
	// ------------------------------------------------------------------

	// Offers one instruction beat and returns at the falling edge after it
	// has been taken. Called at a falling edge. valid is left high so that
	// the next beat can follow at once; wait_until_drained lowers it.
	task automatic send_instr(input cmd_item_t c);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted_results = {predicted_results, execute_instr(c)};
		sent_items++;
		@(negedge clk);
	endtask

	// Stops offering and waits for every predicted result to come back.
	task automatic wait_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (predicted_results.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Result channel
	// ------------------------------------------------------------------

	// Receiver: ready drops in random bursts while idling is on, and for a
	// long stretch whenever a test asks for one through hold_request.
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_request != 0) begin
					stall_left = hold_request;
					hold_request = 0;
				end else if (idling_on && $urandom_range(0, 4) == 0) begin
					stall_left = $urandom_range(1, 6);
				end
			end
			if (stall_left != 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Every result beat is checked against the oldest prediction, one field
	// at a time.
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			kind_count[res_ch.data.result_kind]++;
			if (predicted_results.size() == 0) begin
				log_failure($sformatf("unexpected result kind %0d value %h target %h",
					res_ch.data.result_kind, res_ch.data.out_value,
					res_ch.data.jump_target));
			end else begin
				want = predicted_results.pop_front();
				if (res_ch.data.result_kind != want.result_kind)
					log_failure($sformatf("result_kind got %0d expected %0d",
						res_ch.data.result_kind, want.result_kind));
				if (res_ch.data.out_value != want.out_value)
					log_failure($sformatf("out_value got %h expected %h (kind %0d)",
						res_ch.data.out_value, want.out_value, want.result_kind));
				if (res_ch.data.jump_target != want.jump_target)
					log_failure($sformatf("jump_target got %h expected %h (kind %0d)",
						res_ch.data.jump_target, want.jump_target, want.result_kind));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// A short hand-written program from reset: underflow on an empty queue,
	// wrap-around in add, sub and mul, division and remainder by zero,
	// register indexes beyond z, every print and jump form, taken and not
	// taken, quit, and an unused code. The sender then pauses until every
	// result is back.
	task automatic test_directed();
		cmd_item_t prog[$];
		prog = {prog, instr(OP_ADD, 0, 0, 0, 0)};                 // empty queue
		prog = {prog, instr(OP_PRN_NQ, 0, 0, 0, 0)};              // empty queue
		prog = {prog, instr(OP_STORE, 0, 0, 0, 0)};               // empty queue
		prog = {prog, instr(OP_PUSH, 0, 0, {DATA_W{1'b1}}, 0)};
		prog = {prog, instr(OP_PUSH, 0, 0, 1, 0)};
		prog = {prog, instr(OP_ADD, 0, 0, 0, 0)};                 // wraps to zero
		prog = {prog, instr(OP_PUSH, 0, 0, 1, 0)};
		prog = {prog, instr(OP_SUB, 0, 0, 0, 0)};                 // 0 - 1 wraps
		prog = {prog, instr(OP_STORE, NUM_REGS - 1, 0, 0, 0)};    // z = all ones
		prog = {prog, instr(OP_PRN_NR, NUM_REGS - 1, 0, 0, 0)};
		prog = {prog, instr(OP_PRN_CR, NUM_REGS - 1, 0, 0, 0)};   // low byte only
		prog = {prog, instr(OP_PUSH, 0, 0, 5, 0)};
		prog = {prog, instr(OP_PUSH, 0, 0, 0, 0)};
		prog = {prog, instr(OP_DIV, 0, 0, 0, 0)};                 // divide by zero
		prog = {prog, instr(OP_PUSH, 0, 0, 0, 0)};
		prog = {prog, instr(OP_MOD, 0, 0, 0, 0)};                 // remainder by zero
		prog = {prog, instr(OP_STORE, REG_LAST_INDEX, 0, 0, 0)};  // pops, discards
		prog = {prog, instr(OP_LOAD, NUM_REGS, 0, 0, 0)};         // reads as zero
		prog = {prog, instr(OP_PRN_CQ, 0, 0, 0, 0)};
		prog = {prog, instr(OP_LOAD, NUM_REGS - 1, 0, 0, 0)};
		prog = {prog, instr(OP_LOAD, NUM_REGS - 1, 0, 0, 0)};
		prog = {prog, instr(OP_MUL, 0, 0, 0, 0)};                 // all ones squared
		prog = {prog, instr(OP_PRN_NQ, 0, 0, 0, 0)};
		prog = {prog, instr(OP_JMP, 0, 0, 0, TGT_LAST)};
		prog = {prog, instr(OP_JZ, REG_LAST_INDEX, 0, 0, 0)};     // taken, reads zero
		prog = {prog, instr(OP_JEQ, 0, NUM_REGS - 1, 0, 12'h555)}; // not taken
		prog = {prog, instr(OP_JGT, NUM_REGS - 1, 0, 0, 12'haaa)}; // taken
		prog = {prog, instr(OP_QUIT, 0, 0, 0, 0)};
		prog = {prog, instr(OP_LAST_CODE, REG_LAST_INDEX, REG_LAST_INDEX,
			{DATA_W{1'b1}}, TGT_LAST)};                             // unused code
		foreach (prog[i])
			send_instr(prog[i]);
		wait_until_drained();
	endtask

	// Fills the queue to the brim while the receiver holds off for a long
	// stretch, so the block backs up and stalls its input. Push and load into
	// the full queue must overflow, and an add must not. The queue is left
	// full, and the random part that follows works it back down.
	task automatic test_queue_overflow();
		cmd_item_t c;
		hold_request = LONG_HOLD;
		while (shadow_queue.size() < QUEUE_DEPTH) begin
			c = instr(OP_PUSH, random_reg(), random_reg(), DATA_W'($urandom),
				TGT_W'($urandom));
			if ($urandom_range(0, 7) == 0)
				c.operation = OP_LOAD;
			send_instr(c);
		end
		send_instr(instr(OP_PUSH, 0, 0, DATA_W'($urandom), 0));
		send_instr(instr(OP_LOAD, NUM_REGS - 1, 0, 0, 0));
		send_instr(instr(OP_ADD, 0, 0, 0, 0));
		send_instr(instr(OP_PUSH, 0, 0, {DATA_W{1'b1}}, 0));
		send_instr(instr(OP_PUSH, 0, 0, 0, 0));
		wait_until_drained();
	endtask

	// Random instruction streams with random operands; the closing stretch
	// runs with no idling on either side.
	task automatic test_random_programs();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_TAIL)
				idling_on = 1'b0;
			send_instr(random_instr(shadow_queue.size()));
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		idling_on = 1'b1;
		hold_request = 0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_queue_overflow();
		test_random_programs();

		// Let the last results arrive, then keep watching for any stray result.
		wait_until_drained();
		repeat (40) @(negedge clk);

		$display("Ran %0d instructions, checked %0d result beats; queue reached %0d words.",
			sent_items, results_seen, peak_level);
		$display("Kinds: none %0d, number %0d, char %0d, jump %0d, halt %0d, under %0d, over %0d",
			kind_count[K_NONE], kind_count[K_NUMBER], kind_count[K_CHAR],
			kind_count[K_JUMP], kind_count[K_HALT], kind_count[K_UNDER], kind_count[K_OVER]);
		if (failures == 0 && predicted_results.size() == 0)
			$display("PASS queue_machine_executor");
		else
			$display("FAIL queue_machine_executor");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL queue_machine_executor");
		$finish;
	end

endmodule

// File: sim.f
src/qme_pkg.sv
src/qme_if.sv
src/qme_ram.sv
src/qme_alu.sv
src/queue_machine_executor.sv
src/qme_checker.sv
tb/queue_machine_executor_tb.sv
